// ===== rtl/core/ssrch_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrch_pkg
// Shared types, codes and helpers for the stream search with terminator.
// ----------------------------------------------------------------------------
package ssrch_pkg;

  // Longest pattern the matchers handle; longer lengths are clamped to it.
  localparam int MAX_PATTERN = 16;

  localparam int LEN_W     = 5;
  localparam int POS_W     = 5;
  localparam int TICK_W    = 16;
  localparam int PATTERN_W = 128;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Input item kinds, carried on tuser.
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // Search outcomes.
  localparam logic [1:0] OUTCOME_FOUND      = 2'd0;
  localparam logic [1:0] OUTCOME_TERMINATED = 2'd1;
  localparam logic [1:0] OUTCOME_TIMED_OUT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  // Result of one pattern matcher for the byte at hand.
  typedef struct packed {
    logic [POS_W-1:0] pos_next;
    logic             complete;
  } match_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lim;
    lim = LEN_W'(MAX_PATTERN);
    return (len > lim) ? lim : len;
  endfunction

endpackage

// ===== rtl/core/ssrch_matcher.sv =====
// ----------------------------------------------------------------------------
// ssrch_matcher
// Next match position of one pattern for one received byte.
// ----------------------------------------------------------------------------
module ssrch_matcher (
  input  logic [ssrch_pkg::PATTERN_W-1:0] pattern,
  input  logic [ssrch_pkg::LEN_W-1:0]     len,
  input  logic [ssrch_pkg::POS_W-1:0]     pos,
  input  logic [7:0]                      rx_byte,
  output ssrch_pkg::match_t               match
);

  logic [6:0] bit_idx;
  logic [7:0] expected;
  logic       advance;

  assign bit_idx  = {pos[3:0], 3'b000};
  assign expected = pattern[bit_idx +: 8];
  assign advance  = (pos < len) && (rx_byte == expected);

  // A mismatch restarts at zero without comparing this byte again.
  assign match.pos_next = advance ? (pos + 1'b1) : '0;
  assign match.complete = (match.pos_next >= len);

endmodule

// ===== rtl/core/stream_search_with_terminator_core.sv =====
// ----------------------------------------------------------------------------
// stream_search_with_terminator_core
// Searches a byte stream for a target pattern or a terminator pattern.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel; tuser carries the kind (received
// byte, time tick, start search) and tdata the received byte. A start arms the
// search, bytes advance the target and terminator matchers, and ticks with no
// byte in between count toward the timeout. Each search ends with one outcome
// transaction on m_axis (found, terminator seen, timed out); an empty target
// ends the search at the start item. Items other than these give no result.
// The user must write the configuration port only while no transaction is
// in flight; the block itself does not enforce this. An accepted item is held
// in the input register, and its outcome enters the output register when the
// evaluation stage steps. Throughput is one item per cycle while the receiver
// does not stall; the limit is the single evaluation stage between the input
// register and the output register. When the receiver stalls, the held result
// blocks the evaluation stage and tready drops once the input register is full.
// Reset clears the search state, both registers' valid flags and the
// configuration to empty patterns with a timeout of 1000 ticks.
// ----------------------------------------------------------------------------
module stream_search_with_terminator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ssrch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssrch_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]                       s_axis_tuser,  // [1:0] func
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata   // [1:0] outcome, [7:2] zero
);

  // Configuration registers.
  logic [ssrch_pkg::PATTERN_W-1:0] target_bytes;
  logic [ssrch_pkg::PATTERN_W-1:0] stop_bytes;
  logic [ssrch_pkg::LEN_W-1:0]     target_length;
  logic [ssrch_pkg::LEN_W-1:0]     stop_length;
  logic [ssrch_pkg::TICK_W-1:0]    timeout_ticks;

  // Input register.
  logic       in_valid;
  logic [1:0] in_func;
  logic [7:0] in_byte;

  // Search state.
  logic                         searching, searching_next;
  logic [ssrch_pkg::POS_W-1:0]  target_pos, target_pos_next;
  logic [ssrch_pkg::POS_W-1:0]  stop_pos, stop_pos_next;
  logic [ssrch_pkg::TICK_W-1:0] idle_ticks, idle_ticks_next;

  // Output register.
  logic       out_valid;
  logic [1:0] out_code;

  logic                         step;
  logic                         result_valid;
  logic [1:0]                   result_code;
  logic [ssrch_pkg::LEN_W-1:0]  tlen;
  logic [ssrch_pkg::LEN_W-1:0]  slen;
  logic [ssrch_pkg::TICK_W-1:0] limit;
  logic [ssrch_pkg::TICK_W-1:0] ticks_inc;
  ssrch_pkg::match_t            target_match;
  ssrch_pkg::match_t            stop_match;

  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_code};

  assign tlen      = ssrch_pkg::eff_len(target_length);
  assign slen      = ssrch_pkg::eff_len(stop_length);
  assign limit     = (timeout_ticks == '0) ? ssrch_pkg::TICK_W'(1) : timeout_ticks;
  assign ticks_inc = (idle_ticks < ssrch_pkg::TICK_MAX) ? (idle_ticks + 1'b1) : idle_ticks;

  ssrch_matcher u_target (
    .pattern (target_bytes),
    .len     (tlen),
    .pos     (target_pos),
    .rx_byte (in_byte),
    .match   (target_match)
  );

  ssrch_matcher u_stop (
    .pattern (stop_bytes),
    .len     (slen),
    .pos     (stop_pos),
    .rx_byte (in_byte),
    .match   (stop_match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_bytes  <= '0;
      stop_bytes    <= '0;
      target_length <= '0;
      stop_length   <= '0;
      timeout_ticks <= ssrch_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssrch_pkg::REG_TARGET_LOW:  target_bytes[63:0]   <= cfg_data;
        ssrch_pkg::REG_TARGET_HIGH: target_bytes[127:64] <= cfg_data;
        ssrch_pkg::REG_TARGET_LEN:  target_length <= cfg_data[ssrch_pkg::LEN_W-1:0];
        ssrch_pkg::REG_STOP_LOW:    stop_bytes[63:0]     <= cfg_data;
        ssrch_pkg::REG_STOP_HIGH:   stop_bytes[127:64]   <= cfg_data;
        ssrch_pkg::REG_STOP_LEN:    stop_length <= cfg_data[ssrch_pkg::LEN_W-1:0];
        ssrch_pkg::REG_TIMEOUT:     timeout_ticks <= cfg_data[ssrch_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    searching_next  = searching;
    target_pos_next = target_pos;
    stop_pos_next   = stop_pos;
    idle_ticks_next = idle_ticks;
    result_valid    = 1'b0;
    result_code     = ssrch_pkg::OUTCOME_FOUND;
    unique case (in_func)
      ssrch_pkg::FUNC_START: begin
        searching_next  = (tlen != '0);
        target_pos_next = '0;
        stop_pos_next   = '0;
        idle_ticks_next = '0;
        result_valid    = (tlen == '0);
      end
      ssrch_pkg::FUNC_BYTE: begin
        if (searching) begin
          idle_ticks_next = '0;
          target_pos_next = target_match.pos_next;
          stop_pos_next   = stop_match.pos_next;
          // A completed target wins over a terminator completed by the same byte.
          if (target_match.complete) begin
            result_valid = 1'b1;
            result_code  = ssrch_pkg::OUTCOME_FOUND;
          end else if (stop_match.complete) begin
            result_valid = 1'b1;
            result_code  = ssrch_pkg::OUTCOME_TERMINATED;
          end
        end
      end
      ssrch_pkg::FUNC_TICK: begin
        if (searching) begin
          idle_ticks_next = ticks_inc;
          if (ticks_inc >= limit) begin
            result_valid = 1'b1;
            result_code  = ssrch_pkg::OUTCOME_TIMED_OUT;
          end
        end
      end
      default: ;
    endcase
    if (result_valid) begin
      searching_next  = 1'b0;
      target_pos_next = '0;
      stop_pos_next   = '0;
      idle_ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      searching  <= 1'b0;
      target_pos <= '0;
      stop_pos   <= '0;
      idle_ticks <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (step) begin
        out_valid  <= result_valid;
        searching  <= searching_next;
        target_pos <= target_pos_next;
        stop_pos   <= stop_pos_next;
        idle_ticks <= idle_ticks_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
    if (step && result_valid) begin
      out_code <= result_code;
    end
  end

endmodule

// ===== rtl/core/ssrch_checker.sv =====
// ----------------------------------------------------------------------------
// ssrch_checker
// Port-level checks for the stream search with terminator, bound to the top.
// ----------------------------------------------------------------------------
module ssrch_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled outcome stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("outcome changed or dropped while stalled");

  // Only the three defined outcomes are ever reported.
  a_out_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0) &&
                      (m_axis_tdata[1:0] != 2'd3))
    else $error("undefined outcome code");

  // A fresh outcome follows an input transaction that passed the input register and then the output register.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("outcome appeared without a preceding input transaction");

  // With the output register empty, the input side never stalls.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register was empty");

endmodule

bind stream_search_with_terminator_core ssrch_checker u_ssrch_checker (.*);
